// ===== rtl/core/skil_pkg.sv =====
// Shared types and constants for the sorted key index lookup core.
// Holds beat structs, command and status codes, controller states and
// datapath micro-ops. No dependencies.
package skil_pkg;

  localparam int MAX_ENTRIES_DEF = 1024;
  localparam int KEY_BITS_DEF    = 64;
  localparam int KEY_W           = 64;
  localparam int POS_W           = 11;

  localparam logic [1:0] CMD_APPEND = 2'd0;
  localparam logic [1:0] CMD_LOOKUP = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [KEY_W-1:0] key;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic             found;
    logic [POS_W-1:0] position;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_COPY_RD,
    S_COPY_WR,
    S_PASS_INIT,
    S_MERGE_RD,
    S_MERGE_WR,
    S_SRCH_INIT,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_FINAL_CMP,
    S_RESULT
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_APPEND,
    OP_CLEAR,
    OP_COPY_INIT,
    OP_COPY_RD,
    OP_COPY_WR,
    OP_PASS_INIT,
    OP_SORT_DONE,
    OP_MERGE_RD,
    OP_MERGE_WR,
    OP_SRCH_INIT,
    OP_SRCH_RD,
    OP_SRCH_CMP,
    OP_FINAL_RD,
    OP_FINAL_CMP,
    OP_MISS,
    OP_EMIT
  } dp_op_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       sorted_valid;
    logic       count_zero;
    logic       copy_last;
    logic       sort_done;
    logic       run_last;
    logic       pass_last;
    logic       srch_open;
    logic       slo_zero;
    logic       out_free;
  } dp_status_t;

endpackage

// ===== rtl/core/skil_ctrl.sv =====
// Controller state machine for the sorted key index lookup core.
// Sequences capture, append, rebuild (copy and merge passes) and search.
// Depends on skil_pkg.
module skil_ctrl
  import skil_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  dp_status_t st,
  output dp_op_t     op
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    op         = OP_NONE;
    in_stall   = (state != S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          op         = OP_CAPTURE;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        priority if (st.cmd == CMD_APPEND) begin
          op         = OP_APPEND;
          state_next = S_RESULT;
        end else if (st.cmd == CMD_CLEAR) begin
          op         = OP_CLEAR;
          state_next = S_RESULT;
        end else if (st.cmd == CMD_LOOKUP) begin
          if (st.sorted_valid) begin
            state_next = S_SRCH_INIT;
          end else begin
            op         = OP_COPY_INIT;
            state_next = st.count_zero ? S_PASS_INIT : S_COPY_RD;
          end
        end else begin
          state_next = S_RESULT;
        end
      end
      S_COPY_RD: begin
        op         = OP_COPY_RD;
        state_next = S_COPY_WR;
      end
      S_COPY_WR: begin
        op         = OP_COPY_WR;
        state_next = st.copy_last ? S_PASS_INIT : S_COPY_RD;
      end
      S_PASS_INIT: begin
        if (st.sort_done) begin
          op         = OP_SORT_DONE;
          state_next = S_SRCH_INIT;
        end else begin
          op         = OP_PASS_INIT;
          state_next = S_MERGE_RD;
        end
      end
      S_MERGE_RD: begin
        op         = OP_MERGE_RD;
        state_next = S_MERGE_WR;
      end
      S_MERGE_WR: begin
        op         = OP_MERGE_WR;
        state_next = (st.run_last && st.pass_last) ? S_PASS_INIT : S_MERGE_RD;
      end
      S_SRCH_INIT: begin
        op         = OP_SRCH_INIT;
        state_next = S_SRCH_RD;
      end
      S_SRCH_RD: begin
        priority if (st.srch_open) begin
          op         = OP_SRCH_RD;
          state_next = S_SRCH_CMP;
        end else if (st.slo_zero) begin
          op         = OP_MISS;
          state_next = S_RESULT;
        end else begin
          op         = OP_FINAL_RD;
          state_next = S_FINAL_CMP;
        end
      end
      S_SRCH_CMP: begin
        op         = OP_SRCH_CMP;
        state_next = S_SRCH_RD;
      end
      S_FINAL_CMP: begin
        op         = OP_FINAL_CMP;
        state_next = S_RESULT;
      end
      S_RESULT: begin
        if (st.out_free) begin
          op         = OP_EMIT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/skil_dp.sv =====
// Datapath for the sorted key index lookup core: key store, two ping-pong
// sort buffers of {key, load position}, merge and search counters, result
// and output registers. Depends on skil_pkg.
module skil_dp
  import skil_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
  parameter int KEY_BITS    = KEY_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  dp_op_t     op,
  output dp_status_t st,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_data
);

  localparam int AW    = $clog2(MAX_ENTRIES);
  localparam int CW    = $clog2(MAX_ENTRIES + 1);
  localparam int LW    = CW + 2;
  localparam int ENT_W = KEY_BITS + AW;

  logic [KEY_BITS-1:0] key_store [MAX_ENTRIES];
  logic [ENT_W-1:0]    buf0 [MAX_ENTRIES];
  logic [ENT_W-1:0]    buf1 [MAX_ENTRIES];

  logic [1:0]          cmdq;
  logic [KEY_BITS-1:0] kin;
  logic [CW-1:0]       count;
  logic                sorted_valid;
  logic [CW-1:0]       cidx;
  logic                src;
  logic [LW-1:0]       w, mid, hi, a, b, o;
  logic [CW-1:0]       slo, shi, smid;
  logic [KEY_BITS-1:0] ks_rd;
  logic [ENT_W-1:0]    rd0a, rd1a, rd0b, rd1b;
  out_item_t           res;

  logic [LW-1:0]       n_l, hi_w, hi_2w, w2;
  logic [CW:0]         cnt_inc;
  logic [CW:0]         mid_sum;
  logic [ENT_W-1:0]    ea, eb, pick;
  logic [KEY_BITS-1:0] ka, kb;
  logic [AW-1:0]       pa;
  logic                a_ok, b_ok, take_b;
  logic [AW-1:0]       ra;
  logic                wr0_en, wr1_en;
  logic [AW-1:0]       wr_addr;
  logic [ENT_W-1:0]    wr_data;

  assign n_l     = LW'(count);
  assign w2      = w << 1;
  assign hi_w    = hi + w;
  assign hi_2w   = hi + w2;
  assign cnt_inc = {1'b0, count} + 1'b1;
  assign mid_sum = {1'b0, slo} + {1'b0, shi};

  assign ea   = src ? rd1a : rd0a;
  assign eb   = src ? rd1b : rd0b;
  assign ka   = ea[ENT_W-1:AW];
  assign kb   = eb[ENT_W-1:AW];
  assign pa   = ea[AW-1:0];
  assign a_ok = (a < mid);
  assign b_ok = (b < hi);
  // Stable merge: take the right run only when its key is strictly smaller or the left run is used up.
  assign take_b = b_ok && (!a_ok || (kb < ka));
  assign pick   = take_b ? eb : ea;

  always_comb begin
    ra = a[AW-1:0];
    if (op == OP_SRCH_RD) begin
      ra = AW'(mid_sum >> 1);
    end else if (op == OP_FINAL_RD) begin
      ra = AW'(slo - 1'b1);
    end
  end

  always_comb begin
    wr0_en  = 1'b0;
    wr1_en  = 1'b0;
    wr_addr = o[AW-1:0];
    wr_data = pick;
    if (op == OP_COPY_WR) begin
      wr0_en  = 1'b1;
      wr_addr = cidx[AW-1:0];
      wr_data = {ks_rd, cidx[AW-1:0]};
    end else if (op == OP_MERGE_WR) begin
      wr0_en = src;
      wr1_en = !src;
    end
  end

  always_ff @(posedge clk) begin
    if (op == OP_APPEND && count < CW'(MAX_ENTRIES)) begin
      key_store[count[AW-1:0]] <= kin;
    end
    ks_rd <= key_store[cidx[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (wr0_en) begin
      buf0[wr_addr] <= wr_data;
    end
    rd0a <= buf0[ra];
    rd0b <= buf0[b[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (wr1_en) begin
      buf1[wr_addr] <= wr_data;
    end
    rd1a <= buf1[ra];
    rd1b <= buf1[b[AW-1:0]];
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      sorted_valid <= 1'b0;
      out_valid    <= 1'b0;
      src          <= 1'b0;
    end else begin
      if (op == OP_EMIT) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (op)
        OP_APPEND: begin
          if (count < CW'(MAX_ENTRIES)) begin
            count        <= count + 1'b1;
            sorted_valid <= 1'b0;
          end
        end
        OP_CLEAR: begin
          count        <= '0;
          sorted_valid <= 1'b0;
        end
        OP_COPY_INIT: begin
          src <= 1'b0;
        end
        OP_MERGE_WR: begin
          if ((o + 1'b1 == hi) && (hi >= n_l)) begin
            src <= !src;
          end
        end
        OP_SORT_DONE: begin
          sorted_valid <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Payload and counter registers.
  always_ff @(posedge clk) begin
    unique case (op)
      OP_CAPTURE: begin
        cmdq <= in_data.cmd;
        kin  <= in_data.key[KEY_BITS-1:0];
        res  <= '{status: ST_OK, found: 1'b0, position: '0};
      end
      OP_APPEND: begin
        res.position <= POS_W'(count);
        if (count >= CW'(MAX_ENTRIES)) begin
          res.status <= ST_FULL;
        end
      end
      OP_COPY_INIT: begin
        cidx <= '0;
        w    <= LW'(1);
      end
      OP_COPY_WR: begin
        cidx <= cidx + 1'b1;
      end
      OP_PASS_INIT: begin
        a   <= '0;
        o   <= '0;
        mid <= (w < n_l) ? w : n_l;
        b   <= (w < n_l) ? w : n_l;
        hi  <= (w2 < n_l) ? w2 : n_l;
      end
      OP_MERGE_WR: begin
        if ((o + 1'b1 == hi) && (hi < n_l)) begin
          // Advance to the next pair of runs.
          a   <= hi;
          o   <= hi;
          mid <= (hi_w < n_l) ? hi_w : n_l;
          b   <= (hi_w < n_l) ? hi_w : n_l;
          hi  <= (hi_2w < n_l) ? hi_2w : n_l;
        end else begin
          o <= o + 1'b1;
          if (take_b) begin
            b <= b + 1'b1;
          end else begin
            a <= a + 1'b1;
          end
          if (o + 1'b1 == hi) begin
            w <= w2;
          end
        end
      end
      OP_SRCH_INIT: begin
        slo <= '0;
        shi <= count;
      end
      OP_SRCH_RD: begin
        smid <= CW'(mid_sum >> 1);
      end
      OP_SRCH_CMP: begin
        // Upper bound: find the first slot whose key exceeds the target.
        if (ka <= kin) begin
          slo <= smid + 1'b1;
        end else begin
          shi <= smid;
        end
      end
      OP_MISS: begin
        res.status   <= ST_NOT_FOUND;
        res.position <= POS_W'(cnt_inc);
      end
      OP_FINAL_CMP: begin
        if (ka == kin) begin
          res.found    <= 1'b1;
          res.position <= POS_W'(pa);
        end else begin
          res.status   <= ST_NOT_FOUND;
          res.position <= POS_W'(cnt_inc);
        end
      end
      OP_EMIT: begin
        out_data <= res;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    st.cmd          = cmdq;
    st.sorted_valid = sorted_valid;
    st.count_zero   = (count == '0);
    st.copy_last    = ({1'b0, cidx} + 1'b1 == {1'b0, count});
    st.sort_done    = (w >= n_l);
    st.run_last     = (o + 1'b1 == hi);
    st.pass_last    = (hi >= n_l);
    st.srch_open    = (slo < shi);
    st.slo_zero     = (slo == '0);
    st.out_free     = !out_valid || !out_stall;
  end

endmodule

// ===== rtl/core/sorted_key_index_lookup_core.sv =====
// Sorted key index lookup core. Append and clear pass from decode straight
// to the result state; a lookup on a current sorted copy runs a binary
// search, with a read and a compare state per probe of the sorted buffer.
// The first lookup after a change first rebuilds: a copy of the key store
// into a sort buffer, then ceil(log2 n) merge passes, and a last step to
// close the sort.
// Synchronous reset empties the table; the memories need no clearing.
module sorted_key_index_lookup_core
  import skil_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
  parameter int KEY_BITS    = KEY_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  dp_op_t     op;
  dp_status_t st;

  skil_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .op       (op)
  );

  skil_dp #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .KEY_BITS    (KEY_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .op        (op),
    .st        (st),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
